@@ src/eare_pkg.sv @@
package eare_pkg;

  // operand widths after the counters are summed
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PACK_IN_W  = 33;
  localparam int unsigned DIVIDEND_W = 34;
  localparam int unsigned DIVISOR_W  = 33;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned THR_W      = PCT_W + CNT_W;

  localparam int unsigned MANT_BITS  = 13;
  localparam int unsigned EXP_BITS   = 3;
  localparam logic [15:0] PACK_SAT   = 16'hFFFF;
  localparam logic [15:0] MEM_SAT    = 16'hFFFF;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam int unsigned N_LANES    = 4;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_SUSPEND = 2'd1;
  localparam logic [1:0] REG_RESUME  = 2'd2;

  localparam logic [PCT_W-1:0] SUSPEND_RESET = 7'd2;
  localparam logic [PCT_W-1:0] RESUME_RESET  = 7'd4;

  // space event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_RESUME  = 2'd1;
  localparam logic [1:0] EV_SUSPEND = 2'd2;

  typedef struct packed {
    logic        done;
    logic [15:0] code;
  } lane_status_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_status_t;

endpackage

@@ src/eare_pack_lane.sv @@
module eare_pack_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [eare_pkg::PACK_IN_W-1:0]    value,
  output eare_pkg::lane_status_t            status
);

  logic                                  busy;
  logic                                  done;
  logic [eare_pkg::PACK_IN_W-1:0]        t;
  logic [eare_pkg::EXP_BITS-1:0]         ex;
  logic                                  rnd;
  logic [15:0]                           code;

  logic                                  big;
  logic [eare_pkg::MANT_BITS:0]          inc;
  logic [eare_pkg::MANT_BITS-1:0]        mant;
  logic [eare_pkg::EXP_BITS:0]           ex_fin;
  logic [15:0]                           code_next;

  assign big = |t[eare_pkg::PACK_IN_W-1:eare_pkg::MANT_BITS];
  assign inc = {1'b0, t[eare_pkg::MANT_BITS-1:0]} + {{eare_pkg::MANT_BITS{1'b0}}, 1'b1};

  // round on the last dropped group, renormalize if the carry reaches the limit
  always_comb begin
    mant   = t[eare_pkg::MANT_BITS-1:0];
    ex_fin = {1'b0, ex};
    if (rnd) begin
      if (inc[eare_pkg::MANT_BITS]) begin
        mant   = eare_pkg::MANT_BITS'(inc >> 3);
        ex_fin = {1'b0, ex} + 4'd1;
      end else begin
        mant = inc[eare_pkg::MANT_BITS-1:0];
      end
    end
    if (ex_fin[eare_pkg::EXP_BITS]) begin
      code_next = eare_pkg::PACK_SAT;
    end else begin
      code_next = {ex_fin[eare_pkg::EXP_BITS-1:0], mant};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      t    <= value;
      ex   <= '0;
      rnd  <= 1'b0;
    end else if (busy) begin
      if (big) begin
        ex  <= ex + 3'd1;
        rnd <= t[2];
        t   <= t >> 3;
      end else begin
        busy <= 1'b0;
        done <= 1'b1;
        code <= code_next;
      end
    end
  end

  assign status.done = done;
  assign status.code = code;

endmodule

@@ src/eare_divider.sv @@
module eare_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [eare_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [eare_pkg::DIVISOR_W-1:0]    divisor,
  output eare_pkg::div_status_t             status
);

  logic                                  busy;
  logic                                  done;
  logic [eare_pkg::DIV_CNT_W-1:0]        cnt;
  logic [eare_pkg::DIVIDEND_W-1:0]       q;
  logic [eare_pkg::DIVISOR_W-1:0]        rem;
  logic [eare_pkg::DIVISOR_W-1:0]        d;
  logic [15:0]                           quotient;

  logic [eare_pkg::DIVISOR_W:0]          rs;
  logic                                  fits;
  logic [eare_pkg::DIVIDEND_W-1:0]       q_next;
  logic [eare_pkg::DIVISOR_W-1:0]        rem_next;

  // one restoring step per cycle
  assign rs       = {rem, q[eare_pkg::DIVIDEND_W-1]};
  assign fits     = rs >= {1'b0, d};
  assign rem_next = fits ? eare_pkg::DIVISOR_W'(rs - {1'b0, d})
                         : rs[eare_pkg::DIVISOR_W-1:0];
  assign q_next   = {q[eare_pkg::DIVIDEND_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      if (divisor == '0) begin
        busy     <= 1'b0;
        done     <= 1'b1;
        quotient <= '0;
      end else begin
        busy <= 1'b1;
        done <= 1'b0;
      end
      cnt <= '0;
      q   <= dividend;
      rem <= '0;
      d   <= divisor;
    end else if (busy) begin
      q   <= q_next;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
      if (cnt == eare_pkg::DIV_CNT_W'(eare_pkg::DIVIDEND_W - 1)) begin
        busy     <= 1'b0;
        done     <= 1'b1;
        quotient <= (|q_next[eare_pkg::DIVIDEND_W-1:16]) ? eare_pkg::MEM_SAT : q_next[15:0];
      end
    end
  end

  assign status.done     = done;
  assign status.quotient = quotient;

endmodule

@@ src/exit_accounting_record_encoder_top.sv @@
// exit accounting record encoder
//
// s_* channel: one process-exit event per transfer, eleven 32-bit counters in
// s_tdata. m_* channel: exactly one result per event; m_tuser carries the
// record flag and the space event, m_tdata the packed times, I/O and memory.
// cfg_* channel: register writes (0 enable, 1 suspend percent, 2 resume
// percent), taken only while no event is in flight and the output is empty;
// a write to register 0 clears the suspended state.
//
// the space decision is registered after the threshold multiply (ST_MUL) and
// the compare (ST_DECIDE). a record then needs the four packing lanes (in
// parallel) and the 34-step restoring divider for the average memory before
// the result is loaded. one item is worked on at a time; the next event is
// taken once the result sits in the output register and the block is idle
// again, unless a register write is pending.
//
// reset clears the control state, disables logging and loads the default
// thresholds. a stalled receiver holds the result in m_tdata/m_tuser; the
// block takes one more event and then waits until the output register frees.
module exit_accounting_record_encoder_top #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // user_seconds, system_seconds, now_seconds, start_seconds, blocks_read,
  // blocks_written, text_rss_integral, data_rss_integral, stack_rss_integral,
  // free_blocks, total_blocks (32 bits each)
  input  logic [351:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // packed_user_time, packed_system_time, packed_elapsed_time,
  // packed_io_blocks, average_memory (16 bits each)
  output logic [79:0]  m_tdata,
  // record_valid, space_event[1:0]
  output logic [2:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  localparam int unsigned CW = (COUNTER_BITS < 32) ? COUNTER_BITS : 32;
  localparam logic [31:0] CNT_MASK = 32'hFFFF_FFFF >> (32 - CW);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_WORK   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;

  logic                               enabled;
  logic [eare_pkg::PCT_W-1:0]         suspend_pct;
  logic [eare_pkg::PCT_W-1:0]         resume_pct;
  logic                               suspended;

  logic [31:0]                        usr_w, sys_w, now_w, start_w, rd_w, wr_w;
  logic [31:0]                        rt_w, rdt_w, rs_w;

  logic [eare_pkg::PACK_IN_W-1:0]     usr_r, sys_r, elapsed_r, io_r;
  logic [eare_pkg::DIVISOR_W-1:0]     cpu_r;
  logic [eare_pkg::DIVIDEND_W-1:0]    rss_r;
  logic [31:0]                        free_r, total_r;

  logic [eare_pkg::THR_W-1:0]         thr_susp, thr_res, free100;
  logic                               resume_ok, susp_hit;

  logic                               res_record;
  logic [1:0]                         res_event;
  logic                               work_start;

  eare_pkg::lane_status_t             lane_st [eare_pkg::N_LANES];
  logic [eare_pkg::PACK_IN_W-1:0]     lane_in [eare_pkg::N_LANES];
  logic [eare_pkg::N_LANES-1:0]       lane_done;
  eare_pkg::div_status_t              div_st;

  logic                               out_free;

  // a pending register write goes first
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE) && !m_tvalid;
  assign out_free  = !m_tvalid || m_tready;

  assign usr_w   = s_tdata[31:0]    & CNT_MASK;
  assign sys_w   = s_tdata[63:32]   & CNT_MASK;
  assign now_w   = s_tdata[95:64];
  assign start_w = s_tdata[127:96];
  assign rd_w    = s_tdata[159:128] & CNT_MASK;
  assign wr_w    = s_tdata[191:160] & CNT_MASK;
  assign rt_w    = s_tdata[223:192] & CNT_MASK;
  assign rdt_w   = s_tdata[255:224] & CNT_MASK;
  assign rs_w    = s_tdata[287:256] & CNT_MASK;

  // floor(p * total / 100) < free  <=>  p * total < 100 * free
  assign resume_ok = thr_res < free100;
  assign susp_hit  = thr_susp >= free100;

  assign work_start = (state == ST_DECIDE) && enabled && (!suspended || resume_ok) && !susp_hit;

  assign lane_in[0] = usr_r;
  assign lane_in[1] = sys_r;
  assign lane_in[2] = elapsed_r;
  assign lane_in[3] = io_r;

  for (genvar g = 0; g < eare_pkg::N_LANES; g++) begin : g_lane
    eare_pack_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (work_start),
      .value  (lane_in[g]),
      .status (lane_st[g])
    );
    assign lane_done[g] = lane_st[g].done;
  end

  eare_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (work_start),
    .dividend (rss_r),
    .divisor  (cpu_r),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      enabled     <= 1'b0;
      suspend_pct <= eare_pkg::SUSPEND_RESET;
      resume_pct  <= eare_pkg::RESUME_RESET;
      suspended   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // the finish state reloads the output itself
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            usr_r     <= {1'b0, usr_w};
            sys_r     <= {1'b0, sys_w};
            elapsed_r <= (now_w >= start_w) ? {1'b0, now_w - start_w} : '0;
            io_r      <= {1'b0, rd_w} + {1'b0, wr_w};
            cpu_r     <= {1'b0, usr_w} + {1'b0, sys_w};
            rss_r     <= {2'b0, rt_w} + {2'b0, rdt_w} + {2'b0, rs_w};
            free_r    <= s_tdata[319:288];
            total_r   <= s_tdata[351:320];
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          thr_susp <= eare_pkg::THR_W'(suspend_pct) * eare_pkg::THR_W'(total_r);
          thr_res  <= eare_pkg::THR_W'(resume_pct) * eare_pkg::THR_W'(total_r);
          free100  <= eare_pkg::THR_W'(free_r) * eare_pkg::THR_W'(eare_pkg::PCT_SCALE);
          state    <= ST_DECIDE;
        end
        ST_DECIDE: begin
          res_record <= 1'b0;
          res_event  <= eare_pkg::EV_NONE;
          state      <= ST_FINISH;
          priority if (!enabled) begin
            res_event <= eare_pkg::EV_NONE;
          end else if (suspended && !resume_ok) begin
            res_event <= eare_pkg::EV_NONE;
          end else if (susp_hit) begin
            // covers resume and re-suspend in the same event
            suspended <= 1'b1;
            res_event <= eare_pkg::EV_SUSPEND;
          end else begin
            suspended  <= 1'b0;
            res_record <= 1'b1;
            res_event  <= suspended ? eare_pkg::EV_RESUME : eare_pkg::EV_NONE;
            state      <= ST_WORK;
          end
        end
        ST_WORK: begin
          if ((&lane_done) && div_st.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {res_event, res_record};
            if (res_record) begin
              m_tdata <= {div_st.quotient, lane_st[3].code, lane_st[2].code,
                          lane_st[1].code, lane_st[0].code};
            end else begin
              m_tdata <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // configuration writes arrive only while idle
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          eare_pkg::REG_ENABLE: begin
            enabled   <= cfg_data[0];
            suspended <= 1'b0;
          end
          eare_pkg::REG_SUSPEND: suspend_pct <= cfg_data;
          eare_pkg::REG_RESUME:  resume_pct  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_record_on_suspend: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && (m_tuser[2:1] == eare_pkg::EV_SUSPEND)))
    else $error("record emitted together with a suspend event");

  a_event_code_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[2:1] != 2'd3))
    else $error("illegal space event code");

  a_empty_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("payload not cleared on a result without a record");

  a_record_units_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && res_record) |-> ((&lane_done) && div_st.done))
    else $error("record finished before lanes and divider completed");

  a_suspend_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && res_event == eare_pkg::EV_SUSPEND && !cfg_valid) |-> suspended)
    else $error("suspend event without suspended state");
`endif

endmodule
